// ----- src/fwq_pkg.sv -----
// ----------------------------------------------------------------------------
// fwq_pkg
// Shared types and constants for the futex wait queue table.
// ----------------------------------------------------------------------------
package fwq_pkg;

    localparam int ADDR_W          = 48;
    localparam int WORD_W          = 32;
    localparam int THREAD_W        = 6;
    localparam int COUNT_W         = 7;
    localparam int NUM_QUEUES_DEF  = 16;
    localparam int MAX_THREADS_DEF = 64;
    localparam int FIFO_DEPTH      = 2;
    localparam logic [1:0] ALIGN_MASK = 2'h3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_FAULT = 2'd2,
        ST_AGAIN = 2'd3
    } t_status;

    typedef enum logic {
        CMD_WAIT = 1'b0,
        CMD_WAKE = 1'b1
    } t_cmd_code;

    // classified request kinds handed from front to back
    typedef enum logic [1:0] {
        OP_ERR  = 2'd0,
        OP_WAIT = 2'd1,
        OP_WAKE = 2'd2
    } t_op;

    typedef struct packed {
        t_cmd_code           cmd;
        logic [ADDR_W-1:0]   word_address;
        logic                translation_fault;
        logic [WORD_W-1:0]   current_word;
        logic [WORD_W-1:0]   expected_word;
        logic [THREAD_W-1:0] thread_number;
        logic                wake_all;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic                should_block;
        logic                woken_valid;
        logic [THREAD_W-1:0] woken_thread;
        logic [COUNT_W-1:0]  woken_count;
        logic                last;
    } t_out_item;

    typedef struct packed {
        t_op                 op;
        t_status             status;
        logic [ADDR_W-1:0]   addr;
        logic [THREAD_W-1:0] thread;
        logic                wake_all;
    } t_cmd;

endpackage

// ----- src/futex_wait_queue_table.sv -----
// ----------------------------------------------------------------------------
// futex_wait_queue_table
// Wait queues keyed by word address: wait appends a thread, wake pops them.
// ----------------------------------------------------------------------------
//  channel | valid        | stall         | payload
//  --------+--------------+---------------+---------------------------
//  request | i_in_valid   | o_in_stall    | i_in_data  (t_in_item)
//  result  | o_out_valid  | i_out_stall   | o_out_data (t_out_item)
//
//  Steps: an error or wait passes through the back end states pop, key match,
//    encode plus pointer read and decide; a wake then emits one result per
//    woken thread, each after a registered read of the waiter link memory.
//  The front classifies in the accept cycle; a 2-entry queue buffers requests.
//  Reset (synchronous, active low) clears queue valid and waiting bits.
//  A result waits in the output register while i_out_stall is high; the back
//    end holds in its decide or emit state until the register frees.
// ----------------------------------------------------------------------------
module futex_wait_queue_table #(
    parameter int NUM_QUEUES  = fwq_pkg::NUM_QUEUES_DEF,
    parameter int MAX_THREADS = fwq_pkg::MAX_THREADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fwq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fwq_pkg::t_out_item o_out_data
);

    fwq_pkg::t_cmd push_cmd, pop_cmd;
    logic          push, pop, full, empty;

    // classify each request as it is accepted
    fwq_front #(
        .MAX_THREADS (MAX_THREADS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_fifo_full (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decouples intake from the table walk
    fwq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_cmd)
    );

    // table lookup, linking and result generation
    fwq_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .MAX_THREADS (MAX_THREADS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- src/fwq_front.sv -----
// ----------------------------------------------------------------------------
// fwq_front
// Request intake: checks alignment, fault, word compare and thread range.
// ----------------------------------------------------------------------------
module fwq_front #(
    parameter int MAX_THREADS = fwq_pkg::MAX_THREADS_DEF
) (
    input  logic             i_in_valid,
    input  fwq_pkg::t_in_item i_in_data,
    output logic             o_in_stall,
    input  logic             i_fifo_full,
    output logic             o_push,
    output fwq_pkg::t_cmd    o_cmd
);

    assign o_in_stall = i_fifo_full;
    assign o_push     = i_in_valid && !i_fifo_full;

    always_comb begin
        o_cmd.addr     = i_in_data.word_address;
        o_cmd.thread   = i_in_data.thread_number;
        o_cmd.wake_all = i_in_data.wake_all;
        o_cmd.status   = fwq_pkg::ST_OK;
        o_cmd.op       = fwq_pkg::OP_WAIT;
        priority if ((i_in_data.word_address[1:0] & fwq_pkg::ALIGN_MASK) != 2'b00) begin
            o_cmd.op     = fwq_pkg::OP_ERR;
            o_cmd.status = fwq_pkg::ST_INVAL;
        end else if (i_in_data.translation_fault) begin
            o_cmd.op     = fwq_pkg::OP_ERR;
            o_cmd.status = fwq_pkg::ST_FAULT;
        end else if (i_in_data.cmd == fwq_pkg::CMD_WAKE) begin
            o_cmd.op     = fwq_pkg::OP_WAKE;
        end else if (i_in_data.current_word != i_in_data.expected_word
                     || int'(i_in_data.thread_number) >= MAX_THREADS) begin
            o_cmd.op     = fwq_pkg::OP_ERR;
            o_cmd.status = fwq_pkg::ST_AGAIN;
        end else begin
            o_cmd.op     = fwq_pkg::OP_WAIT;
        end
    end

endmodule

// ----- src/fwq_fifo.sv -----
// ----------------------------------------------------------------------------
// fwq_fifo
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module fwq_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fwq_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output fwq_pkg::t_cmd o_data
);

    localparam int PW = $clog2(fwq_pkg::FIFO_DEPTH);

    fwq_pkg::t_cmd r_mem [fwq_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(fwq_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- src/fwq_back.sv -----
// ----------------------------------------------------------------------------
// fwq_back
// Queue table: key match, waiter linking, wake walk and result register.
// ----------------------------------------------------------------------------
module fwq_back #(
    parameter int NUM_QUEUES  = fwq_pkg::NUM_QUEUES_DEF,
    parameter int MAX_THREADS = fwq_pkg::MAX_THREADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  fwq_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output fwq_pkg::t_out_item o_out_data
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int TW = $clog2(MAX_THREADS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOK   = 6'b000010,
        S_FIND   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_WKRD   = 6'b010000,
        S_WKEMIT = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    fwq_pkg::t_cmd              r_cmd;
    logic [NUM_QUEUES-1:0]      r_hit, r_free, r_qvalid;
    logic [fwq_pkg::ADDR_W-1:0] r_key [NUM_QUEUES];
    logic [MAX_THREADS-1:0]     r_waiting;
    logic                       r_busy, r_found, r_anyfree;
    logic [QW-1:0]              r_q, r_fq;
    logic [TW-1:0]              r_head_rd, r_tail_rd, r_next_rd, r_h, r_tl;
    logic [fwq_pkg::COUNT_W-1:0] r_n;
    logic                       r_ov;
    fwq_pkg::t_out_item         r_out;

    logic [TW-1:0] head_mem [NUM_QUEUES];
    logic [TW-1:0] tail_mem [NUM_QUEUES];
    logic [TW-1:0] next_mem [MAX_THREADS];

    logic [QW-1:0] enc_q, enc_f, rd_addr;
    logic          enc_found, enc_free;

    logic               can_emit, emit;
    fwq_pkg::t_out_item emit_item;
    logic               head_we, tail_we, next_we, qv_set, qv_clr, wt_set, wt_clr;
    logic [QW-1:0]      head_wa, tail_wa;
    logic [TW-1:0]      head_wd, next_wa, wt_idx;
    logic [TW-1:0]      cmd_t;
    logic [fwq_pkg::COUNT_W-1:0] n1;
    logic               empty_now, fin;

    assign cmd_t     = r_cmd.thread[TW-1:0];
    assign can_emit  = !r_ov || !i_out_stall;
    assign n1        = r_n + 1'b1;
    assign empty_now = (r_h == r_tl);
    assign fin       = empty_now || !r_cmd.wake_all
                       || (n1 >= fwq_pkg::COUNT_W'(MAX_THREADS));

    // lowest matching queue and lowest free slot
    always_comb begin
        enc_q     = '0;
        enc_found = 1'b0;
        enc_f     = '0;
        enc_free  = 1'b0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                enc_q     = QW'(i);
                enc_found = 1'b1;
            end
            if (r_free[i]) begin
                enc_f    = QW'(i);
                enc_free = 1'b1;
            end
        end
    end

    assign rd_addr = (r_state == S_FIND) ? enc_q : r_q;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_item = '{status: fwq_pkg::ST_OK, should_block: 1'b0, woken_valid: 1'b0,
                      woken_thread: '0, woken_count: '0, last: 1'b1};
        head_we = 1'b0; head_wa = r_q;  head_wd = r_next_rd;
        tail_we = 1'b0; tail_wa = r_q;
        next_we = 1'b0; next_wa = r_tail_rd;
        qv_set  = 1'b0; qv_clr  = 1'b0;
        wt_set  = 1'b0; wt_clr  = 1'b0; wt_idx = cmd_t;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_FIND;
            S_FIND: n_state = S_DECIDE;
            S_DECIDE: begin
                unique case (r_cmd.op)
                    fwq_pkg::OP_WAIT: begin
                        if (can_emit) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (r_busy || (!r_found && !r_anyfree)) begin
                                emit_item.status = fwq_pkg::ST_AGAIN;
                            end else begin
                                emit_item.should_block = 1'b1;
                                wt_set  = 1'b1;
                                tail_we = 1'b1;
                                if (r_found) begin
                                    next_we = 1'b1;
                                end else begin
                                    qv_set  = 1'b1;
                                    head_we = 1'b1;
                                    head_wa = r_fq;
                                    head_wd = cmd_t;
                                    tail_wa = r_fq;
                                end
                            end
                        end
                    end
                    fwq_pkg::OP_WAKE: begin
                        if (r_found) begin
                            n_state = S_WKRD;
                        end else if (can_emit) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (can_emit) begin
                            emit             = 1'b1;
                            emit_item.status = r_cmd.status;
                            n_state          = S_IDLE;
                        end
                    end
                endcase
            end
            S_WKRD: n_state = S_WKEMIT;
            S_WKEMIT: begin
                if (can_emit) begin
                    emit                   = 1'b1;
                    emit_item.woken_valid  = 1'b1;
                    emit_item.woken_thread = fwq_pkg::THREAD_W'(r_h);
                    emit_item.woken_count  = n1;
                    emit_item.last         = fin;
                    wt_clr                 = 1'b1;
                    wt_idx                 = r_h;
                    if (empty_now) qv_clr  = 1'b1;
                    else           head_we = 1'b1;
                    n_state = fin ? S_IDLE : S_WKRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_qvalid  <= '0;
            r_waiting <= '0;
        end else begin
            r_state <= n_state;
            if (emit)             r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (qv_set) r_qvalid[r_fq] <= 1'b1;
            if (qv_clr) r_qvalid[r_q]  <= 1'b0;
            if (wt_set) r_waiting[wt_idx] <= 1'b1;
            if (wt_clr) r_waiting[wt_idx] <= 1'b0;
        end
    end

    // payload and table storage
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        if (emit)  r_out <= emit_item;
        if (r_state == S_LOOK) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_hit[i] <= r_qvalid[i] && (r_key[i] == r_cmd.addr);
            end
            r_free <= ~r_qvalid;
            r_busy <= r_waiting[cmd_t];
        end
        if (r_state == S_FIND) begin
            r_q       <= enc_q;
            r_found   <= enc_found;
            r_fq      <= enc_f;
            r_anyfree <= enc_free;
        end
        if (qv_set) r_key[r_fq] <= r_cmd.addr;
        if (r_state == S_DECIDE) begin
            r_h <= r_head_rd;
            r_tl <= r_tail_rd;
            r_n <= '0;
        end
        if (r_state == S_WKEMIT && emit) begin
            r_h <= r_next_rd;
            r_n <= n1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_rd <= head_mem[rd_addr];
        r_tail_rd <= tail_mem[rd_addr];
        r_next_rd <= next_mem[r_h];
        if (head_we) head_mem[head_wa] <= head_wd;
        if (tail_we) tail_mem[tail_wa] <= cmd_t;
        if (next_we) next_mem[next_wa] <= cmd_t;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_woken_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.woken_valid) |-> (r_out.woken_count != '0))
        else $error("woken result with zero count");

    a_walk_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WKRD) |-> r_qvalid[r_q])
        else $error("wake walk on a freed queue");

    a_block_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_item.should_block) |=> r_waiting[$past(cmd_t)])
        else $error("blocked thread not marked waiting");

    a_block_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_item.should_block) |-> (r_cmd.op == fwq_pkg::OP_WAIT))
        else $error("block result from a non-wait request");

endmodule
